FILE: hw/rtl/itcoh_pkg.sv
// Shared types, constants and saturating helpers for the one-site heat block.
package itcoh_pkg;

  localparam int W   = 48;
  localparam int F   = 24;
  localparam int RW  = W + F;
  localparam int SRW = RW / 2 + 3;
  localparam int FW  = 47;

  typedef logic signed [W-1:0] word_t;

  localparam word_t MAXW = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINW = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONEQ = word_t'(1) << F;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic          series_start;
    logic [FW-1:0] host_total;
    logic [FW-1:0] guest_total;
    logic [FW-1:0] injected_volume;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] heat;
    logic                math_error;
  } out_t;

  typedef struct packed {
    in_t  item;
    logic err;
  } job_t;

  typedef struct packed {
    logic [FW-1:0]       binding_constant;
    logic signed [W-1:0] binding_enthalpy;
    logic signed [W-1:0] dilution_slope;
    logic signed [W-1:0] dilution_offset;
    logic                dilution_enable;
    logic [FW-1:0]       stoichiometry;
    logic [FW-1:0]       cell_volume;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    word_t      a;
    word_t      b;
  } arith_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } arith_rsp_t;

  function automatic word_t addq(word_t a, word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? MINW : MAXW;
    return s[W-1:0];
  endfunction

  function automatic word_t subq(word_t a, word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? MINW : MAXW;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(word_t x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic word_t satmag(logic neg, logic [RW:0] q);
    if (!neg) begin
      if (q > {{(RW+1-W){1'b0}}, MAXW}) return MAXW;
      return word_t'(q[W-1:0]);
    end
    if (q[RW:W-1] != '0) return MINW;
    return -word_t'(q[W-1:0]);
  endfunction

endpackage

FILE: hw/rtl/itcoh_front.sv
// Front end: accepts input transactions, flags error cases, queues jobs.
module itcoh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itcoh_pkg::in_t    in_data,
  input  logic              stoich_zero,
  output logic              job_valid,
  output itcoh_pkg::job_t   job,
  input  logic              job_pop
);
  import itcoh_pkg::*;

  job_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  job_t       entry;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  always_comb begin
    entry.item = in_data;
    entry.err  = (in_data.host_total == '0) || stoich_zero;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = job_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, job_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= entry;
  end

endmodule

FILE: hw/rtl/itcoh_arith.sv
// Shared iterative unit: fixed-point multiply, divide and square root.
module itcoh_arith (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itcoh_pkg::arith_req_t req,
  output itcoh_pkg::arith_rsp_t rsp
);
  import itcoh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam int CW = $clog2(RW + 1);
  localparam logic [CW-1:0] MUL_STEPS  = CW'(W / 4);
  localparam logic [CW-1:0] DIV_STEPS  = CW'(RW);
  localparam logic [CW-1:0] SQRT_STEPS = CW'(RW / 2);

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      op_r, op_nxt;
  logic            neg_r, neg_nxt;
  logic [2*W-1:0]  acc_r, acc_nxt;
  logic [2*W-1:0]  mpl_r, mpl_nxt;
  logic [W-1:0]    mb_r, mb_nxt;
  logic [RW-1:0]   num_r, num_nxt;
  logic [RW-1:0]   quo_r, quo_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [W-1:0]    dvs_r, dvs_nxt;
  logic [SRW-1:0]  srem_r, srem_nxt;
  logic [RW/2-1:0] root_r, root_nxt;
  logic            done_r, done_nxt;
  word_t           res_r, res_nxt;

  logic [W:0]      rsh, rdiff;
  logic [SRW-1:0]  ssh, strial;
  logic [SRW:0]    sdiff;
  logic [2*W-1:0]  pp;
  logic [RW:0]     qfin;

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

  always_comb begin
    rsh    = {rem_r, num_r[RW-1]};
    rdiff  = rsh - {1'b0, dvs_r};
    ssh    = {srem_r[SRW-3:0], num_r[RW-1:RW-2]};
    strial = SRW'({root_r, 2'b01});
    sdiff  = {1'b0, ssh} - {1'b0, strial};
    pp     = mpl_r * mb_r[3:0];
    if (op_r == OP_MUL) begin
      qfin = (RW+1)'(acc_r[2*W-1:F]) + (RW+1)'(neg_r && (acc_r[F-1:0] != '0));
    end else begin
      qfin = {1'b0, quo_r} + (RW+1)'(neg_r && (rem_r != '0));
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    mpl_nxt   = mpl_r;
    mb_nxt    = mb_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          neg_nxt = req.a[W-1] ^ req.b[W-1];
          case (req.op)
            OP_MUL: begin
              mpl_nxt   = (2*W)'(mag(req.a));
              mb_nxt    = mag(req.b);
              acc_nxt   = '0;
              cnt_nxt   = MUL_STEPS;
              state_nxt = ST_MUL;
            end
            OP_DIV: begin
              if (req.b == '0) begin
                res_nxt  = (req.a == '0) ? '0 : (req.a[W-1] ? MINW : MAXW);
                done_nxt = 1'b1;
              end else begin
                num_nxt   = {mag(req.a), {F{1'b0}}};
                dvs_nxt   = mag(req.b);
                rem_nxt   = '0;
                quo_nxt   = '0;
                cnt_nxt   = DIV_STEPS;
                state_nxt = ST_DIV;
              end
            end
            OP_SQRT: begin
              num_nxt   = {req.a, {F{1'b0}}};
              srem_nxt  = '0;
              root_nxt  = '0;
              neg_nxt   = 1'b0;
              cnt_nxt   = SQRT_STEPS;
              state_nxt = ST_SQRT;
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        acc_nxt = acc_r + pp;
        mpl_nxt = mpl_r << 4;
        mb_nxt  = mb_r >> 4;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = ST_FIN;
      end
      ST_DIV: begin
        if (!rdiff[W]) begin
          rem_nxt = rdiff[W-1:0];
          quo_nxt = {quo_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt = rsh[W-1:0];
          quo_nxt = {quo_r[RW-2:0], 1'b0};
        end
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = ST_FIN;
      end
      ST_SQRT: begin
        if (!sdiff[SRW]) begin
          srem_nxt = sdiff[SRW-1:0];
          root_nxt = {root_r[RW/2-2:0], 1'b1};
        end else begin
          srem_nxt = ssh;
          root_nxt = {root_r[RW/2-2:0], 1'b0};
        end
        num_nxt = num_r << 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (op_r == OP_SQRT) begin
          res_nxt = word_t'({{(W-RW/2){1'b0}}, root_r});
        end else begin
          res_nxt = satmag(neg_r, qfin);
        end
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    op_r   <= op_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    mpl_r  <= mpl_nxt;
    mb_r   <= mb_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    res_r  <= res_nxt;
  end

endmodule

FILE: hw/rtl/itcoh_back.sv
// Back end: sequences the heat computation on the shared unit, drives results.
module itcoh_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  itcoh_pkg::job_t       job,
  output logic                  job_pop,
  input  itcoh_pkg::cfg_t       cfg,
  output itcoh_pkg::arith_req_t req,
  input  itcoh_pkg::arith_rsp_t rsp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output itcoh_pkg::out_t       out_data
);
  import itcoh_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [3:0] S_NH   = 4'd0;
  localparam logic [3:0] S_A    = 4'd1;
  localparam logic [3:0] S_NHK  = 4'd2;
  localparam logic [3:0] S_B    = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_PHI  = 4'd6;
  localparam logic [3:0] S_VV   = 4'd7;
  localparam logic [3:0] S_PK   = 4'd8;
  localparam logic [3:0] S_VD   = 4'd9;
  localparam logic [3:0] S_HEAT = 4'd10;
  localparam logic [3:0] S_DIL  = 4'd11;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  job_t       job_r, job_nxt;
  word_t      nh_r, nh_nxt;
  word_t      a_r, a_nxt;
  word_t      sum_r, sum_nxt;
  word_t      d_r, d_nxt;
  word_t      phi_r, phi_nxt;
  word_t      t_r, t_nxt;
  word_t      heat_r, heat_nxt;
  word_t      prev_r, prev_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;

  word_t h, g, v, kk, nn, vv, prev, a2, dq;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    h    = word_t'({1'b0, job_r.item.host_total});
    g    = word_t'({1'b0, job_r.item.guest_total});
    v    = word_t'({1'b0, job_r.item.injected_volume});
    kk   = word_t'({1'b0, cfg.binding_constant});
    nn   = word_t'({1'b0, cfg.stoichiometry});
    vv   = word_t'({1'b0, cfg.cell_volume});
    prev = job_r.item.series_start ? '0 : prev_r;
    a2   = addq(a_r, a_r);
    dq   = subq(rsp.result, addq(a2, a2));
  end

  always_comb begin
    req.start = (state_r == ST_ISSUE);
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    case (step_r)
      S_NH:   begin req.a = nn;     req.b = h;                                    end
      S_A:    begin req.op = OP_DIV;  req.a = g;    req.b = nh_r;                end
      S_NHK:  begin req.a = nh_r;   req.b = kk;                                   end
      S_B:    begin req.op = OP_DIV;  req.a = ONEQ; req.b = t_r;                 end
      S_SQ:   begin req.a = sum_r;  req.b = sum_r;                                end
      S_SQRT: begin req.op = OP_SQRT; req.a = d_r;                               end
      S_PHI:  begin req.a = t_r;    req.b = h;                                    end
      S_VV:   begin req.op = OP_DIV;  req.a = v;    req.b = vv;                  end
      S_PK:   begin req.a = prev;   req.b = t_r;                                  end
      S_VD:   begin req.a = vv;     req.b = t_r;                                  end
      S_HEAT: begin req.a = t_r;    req.b = cfg.binding_enthalpy;                 end
      S_DIL:  begin req.a = g;      req.b = cfg.dilution_slope;                   end
      default: begin req.a = '0;    req.b = '0;                                   end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    job_nxt       = job_r;
    nh_nxt        = nh_r;
    a_nxt         = a_r;
    sum_nxt       = sum_r;
    d_nxt         = d_r;
    phi_nxt       = phi_r;
    t_nxt         = t_r;
    heat_nxt      = heat_r;
    prev_nxt      = prev_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    job_pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job;
          step_nxt  = S_NH;
          heat_nxt  = '0;
          state_nxt = job.err ? ST_OUT : ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_BUSY;
      ST_BUSY: begin
        if (rsp.done) begin
          state_nxt = ST_ISSUE;
          step_nxt  = step_r + 1'b1;
          case (step_r)
            S_NH:   nh_nxt  = rsp.result;
            S_A:    a_nxt   = rsp.result;
            S_NHK:  t_nxt   = rsp.result;
            S_B:    sum_nxt = addq(addq(ONEQ, a_r), rsp.result);
            S_SQ:   d_nxt   = dq[W-1] ? '0 : dq;
            S_SQRT: t_nxt   = subq(sum_r, rsp.result);
            S_PHI:  phi_nxt = rsp.result;
            S_VV:   t_nxt   = subq(ONEQ, rsp.result);
            S_PK:   t_nxt   = subq(phi_r, rsp.result);
            S_VD:   t_nxt   = rsp.result;
            S_HEAT: begin
              heat_nxt = rsp.result;
              if (!cfg.dilution_enable) state_nxt = ST_OUT;
            end
            S_DIL: begin
              heat_nxt  = addq(heat_r, addq(rsp.result, cfg.dilution_offset));
              state_nxt = ST_OUT;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.heat       = heat_r;
          out_data_nxt.math_error = job_r.err;
          prev_nxt                = job_r.err ? '0 : phi_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_NH;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    nh_r       <= nh_nxt;
    a_r        <= a_nxt;
    sum_r      <= sum_nxt;
    d_r        <= d_nxt;
    phi_r      <= phi_nxt;
    t_r        <= t_nxt;
    heat_r     <= heat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hw/rtl/itc_one_site_heat_model.sv
// Top level of the one-site binding heat block: config registers and core wiring.
//
// Input channel (in_valid/in_ready/in_data): one transaction per titration
// injection with host and guest totals and injected volume, Q24 fixed point.
// Output channel (out_valid/out_ready/out_data): one transaction per input,
// the injection heat and a math_error flag, in input order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
// always ready; write only while the block is idle.
// Sequencing: one shared iterative unit runs seven multiplies, three divides
// and a square root per item, and dilution adds one more multiply; the back
// end also takes the job from the queue and loads the output register. A
// divide by zero returns without iterating. An item with zero host or zero
// stoichiometry skips the computation and goes straight to the output.
// Flow: the back end works on one item at a time; a two-entry queue takes
// new inputs while the back end works, and the output register holds a
// result while the receiver stalls so the next computation can proceed up
// to its final write.
// Reset: synchronous, active low; clears queue, state and the stored complex
// amount, and loads the register defaults.
module itc_one_site_heat_model (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  itcoh_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output itcoh_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [47:0]      cfg_data
);
  import itcoh_pkg::*;

  localparam logic [2:0] CFG_K      = 3'd0;
  localparam logic [2:0] CFG_DH     = 3'd1;
  localparam logic [2:0] CFG_SLOPE  = 3'd2;
  localparam logic [2:0] CFG_OFFSET = 3'd3;
  localparam logic [2:0] CFG_ENABLE = 3'd4;
  localparam logic [2:0] CFG_N      = 3'd5;
  localparam logic [2:0] CFG_V      = 3'd6;

  cfg_t       cfg_r, cfg_nxt;
  logic       job_valid, job_pop;
  job_t       job;
  arith_req_t req;
  arith_rsp_t rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_K:      cfg_nxt.binding_constant = cfg_data[FW-1:0];
        CFG_DH:     cfg_nxt.binding_enthalpy = cfg_data;
        CFG_SLOPE:  cfg_nxt.dilution_slope   = cfg_data;
        CFG_OFFSET: cfg_nxt.dilution_offset  = cfg_data;
        CFG_ENABLE: cfg_nxt.dilution_enable  = cfg_data[0];
        CFG_N:      cfg_nxt.stoichiometry    = cfg_data[FW-1:0];
        CFG_V:      cfg_nxt.cell_volume      = cfg_data[FW-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.binding_constant <= FW'(ONEQ);
      cfg_r.binding_enthalpy <= '0;
      cfg_r.dilution_slope   <= '0;
      cfg_r.dilution_offset  <= ONEQ;
      cfg_r.dilution_enable  <= 1'b0;
      cfg_r.stoichiometry    <= FW'(ONEQ);
      cfg_r.cell_volume      <= FW'(ONEQ);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  itcoh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .stoich_zero (cfg_r.stoichiometry == '0),
    .job_valid   (job_valid),
    .job         (job),
    .job_pop     (job_pop)
  );

  itcoh_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  itcoh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .cfg       (cfg_r),
    .req       (req),
    .rsp       (rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/itcoh_checker.sv
// Port-level checker for the one-site heat block, bound to the top level.
module itcoh_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input itcoh_pkg::out_t out_data,
  input logic            cfg_ready
);
  import itcoh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.math_error |-> out_data.heat == '0)
    else $error("error result carries nonzero heat");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_ready)
    else $error("output valid right after reset");

endmodule

bind itc_one_site_heat_model itcoh_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

FILE: tb/sv/itc_one_site_heat_model_tb.sv
// Self-checking testbench for the one-site binding heat block with a bit-exact heat predictor.
module itc_one_site_heat_model_tb;

  import itcoh_pkg::*;

  localparam longint QMAX = (64'sd1 <<< 47) - 1;
  localparam longint QMIN = -QMAX - 1;
  localparam longint QONE = 64'sd1 <<< 24;

  localparam logic [2:0] REG_BINDING_CONSTANT = 3'd0;
  localparam logic [2:0] REG_BINDING_ENTHALPY = 3'd1;
  localparam logic [2:0] REG_DILUTION_SLOPE   = 3'd2;
  localparam logic [2:0] REG_DILUTION_OFFSET  = 3'd3;
  localparam logic [2:0] REG_DILUTION_ENABLE  = 3'd4;
  localparam logic [2:0] REG_STOICHIOMETRY    = 3'd5;
  localparam logic [2:0] REG_CELL_VOLUME      = 3'd6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  longint k_val, dh_val, slope_val, offset_val, n_val, vol_val, prev_phi;
  bit     dil_on;
  in_t    pending_items[$];
  out_t   expected_heats[$];
  int     errors = 0;
  int     in_gap = 0;
  int     out_gap = 0;
  bit     calm = 1'b0;

  itc_one_site_heat_model u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint clampq(longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  function automatic longint absq(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint sat_mag(bit neg, logic [127:0] q);
    if (!neg) return (q > 128'(QMAX)) ? QMAX : longint'(q[63:0]);
    if (q > 128'(QMAX)) return QMIN;
    return -longint'(q[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] q;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = 128'(absq(a)) * 128'(absq(b));
    q = p >> 24;
    if (neg && p[23:0] != 0) q = q + 1;
    return sat_mag(neg, q);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    bit neg;
    if (b == 0) return a == 0 ? 0 : (a > 0 ? QMAX : QMIN);
    neg = (a < 0) != (b < 0);
    num = 128'(absq(a)) << 24;
    q = num / 128'(absq(b));
    r = num % 128'(absq(b));
    if (neg && r != 0) q = q + 1;
    return sat_mag(neg, q);
  endfunction

  function automatic longint fx_sqrt(longint x);
    logic [127:0] num;
    logic [127:0] r;
    logic [127:0] c;
    num = 128'(x) << 24;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= num) r = c;
    end
    return (r > 128'(QMAX)) ? QMAX : longint'(r[63:0]);
  endfunction

  function automatic out_t injection_heat(in_t x);
    out_t   o;
    longint h, g, v, prev, nh, a, b, sum, a2, d, phi, keep, diff, heat;
    h = x.host_total;
    g = x.guest_total;
    v = x.injected_volume;
    prev = x.series_start ? 0 : prev_phi;
    o = '0;
    if (h == 0 || n_val == 0) begin
      prev_phi = 0;
      o.math_error = 1'b1;
      return o;
    end
    nh = fx_mul(n_val, h);
    a = fx_div(g, nh);
    b = fx_div(QONE, fx_mul(nh, k_val));
    sum = clampq(clampq(QONE + a) + b);
    a2 = clampq(a + a);
    d = clampq(fx_mul(sum, sum) - clampq(a2 + a2));
    if (d < 0) d = 0;
    phi = fx_mul(clampq(sum - fx_sqrt(d)), h);
    keep = clampq(QONE - fx_div(v, vol_val));
    diff = clampq(phi - fx_mul(prev, keep));
    heat = fx_mul(fx_mul(vol_val, diff), dh_val);
    if (dil_on) heat = clampq(heat + clampq(fx_mul(g, slope_val) + offset_val));
    prev_phi = phi;
    o.heat = heat[47:0];
    return o;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_heats.push_back(injection_heat(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap = calm ? 0 : rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_heats.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction expected none actual heat %0d err %0b",
                   $time, $signed(out_data.heat), out_data.math_error);
        end else begin
          want = expected_heats.pop_front();
          if (want.heat !== out_data.heat) begin
            errors++;
            $display("%0t heat expected %0d actual %0d", $time,
                     $signed(want.heat), $signed(out_data.heat));
          end
          if (want.math_error !== out_data.math_error) begin
            errors++;
            $display("%0t math_error expected %0b actual %0b", $time,
                     want.math_error, out_data.math_error);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = rand_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BINDING_CONSTANT: k_val = val[46:0];
      REG_BINDING_ENTHALPY: dh_val = $signed(val);
      REG_DILUTION_SLOPE:   slope_val = $signed(val);
      REG_DILUTION_OFFSET:  offset_val = $signed(val);
      REG_DILUTION_ENABLE:  dil_on = val[0];
      REG_STOICHIOMETRY:    n_val = val[46:0];
      REG_CELL_VOLUME:      vol_val = val[46:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(longint k, longint dh, longint slope, longint offset, bit en,
                         longint n, longint vol);
    write_reg(REG_BINDING_CONSTANT, 48'(k));
    write_reg(REG_BINDING_ENTHALPY, 48'(dh));
    write_reg(REG_DILUTION_SLOPE, 48'(slope));
    write_reg(REG_DILUTION_OFFSET, 48'(offset));
    write_reg(REG_DILUTION_ENABLE, 48'(en));
    write_reg(REG_STOICHIOMETRY, 48'(n));
    write_reg(REG_CELL_VOLUME, 48'(vol));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_heats.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic in_t make_item(bit s, longint h, longint g, longint v);
    in_t x;
    x.series_start = s;
    x.host_total = h[46:0];
    x.guest_total = g[46:0];
    x.injected_volume = v[46:0];
    return x;
  endfunction

  function automatic longint rand47();
    return longint'({$urandom(), $urandom()}) & QMAX;
  endfunction

  function automatic longint rand_signed();
    return longint'($signed($urandom())) <<< $urandom_range(0, 14);
  endfunction

  task automatic add_series(int len);
    longint h0, gstep, vol;
    h0 = $urandom_range(1 << 12, 1 << 28);
    gstep = longint'($urandom_range(1 << 10, 1 << 26));
    vol = longint'($urandom_range(1 << 12, 1 << 22));
    for (int j = 0; j < len; j++)
      pending_items.push_back(make_item(j == 0, h0 - j * (h0 >> 6), gstep * (j + 1),
                                        vol + $urandom_range(0, 255)));
  endtask

  task automatic add_noise();
    longint h;
    h = ($urandom_range(0, 9) == 0) ? 0 : rand47() >> $urandom_range(0, 40);
    pending_items.push_back(make_item($urandom_range(0, 1), h,
                                      rand47() >> $urandom_range(0, 40),
                                      rand47() >> $urandom_range(0, 40)));
  endtask

  initial begin
    k_val = QONE;  dh_val = 0;  slope_val = 0;  offset_val = QONE;
    dil_on = 1'b0; n_val = QONE; vol_val = QONE; prev_phi = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    pending_items.push_back(make_item(1, QONE, QONE / 2, QONE / 10));
    pending_items.push_back(make_item(0, QONE, QONE, QONE / 10));
    drain();

    set_cfg(QONE * 1000, QONE, 0, 0, 1'b0, QONE, QONE);
    pending_items.push_back(make_item(1, 0, QONE, 0));
    pending_items.push_back(make_item(1, QONE, QONE / 2, QONE / 20));
    pending_items.push_back(make_item(0, QONE, QONE, QONE));
    pending_items.push_back(make_item(0, QONE, 2 * QONE, 2 * QONE));
    pending_items.push_back(make_item(0, QONE, 0, 0));
    pending_items.push_back(make_item(0, 1, QMAX, QMAX));
    pending_items.push_back(make_item(1, QMAX, QMAX, QMAX));
    pending_items.push_back(make_item(0, QMAX, 0, 1));
    pending_items.push_back(make_item(0, QONE / 1000, QONE / 500, QONE / 100));
    drain();

    set_cfg(QMAX, QMIN, QMAX, QMIN, 1'b1, QMAX, QMAX);
    pending_items.push_back(make_item(1, QONE, QONE, QONE));
    pending_items.push_back(make_item(0, QMAX, QMAX, 0));
    pending_items.push_back(make_item(0, 1, 1, QMAX));
    pending_items.push_back(make_item(0, 0, QMAX, QMAX));
    drain();

    set_cfg(0, QMAX, QMIN, QMAX, 1'b1, 0, 1);
    pending_items.push_back(make_item(1, QONE, QONE, QONE));
    pending_items.push_back(make_item(0, QMAX, 1, 0));
    drain();

    set_cfg(0, QONE, QONE, QONE, 1'b0, QONE, 1);
    pending_items.push_back(make_item(1, QONE, QONE, QONE));
    pending_items.push_back(make_item(0, 1, QONE, 1));
    pending_items.push_back(make_item(0, QONE, 0, QMAX));
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        set_cfg(QMAX, QMAX, QMAX, QMAX, 1'b1, 1, QMAX);
      end else begin
        set_cfg(longint'($urandom_range(0, 1 << 16)) << $urandom_range(0, 30), rand_signed(),
                rand_signed(), rand_signed(), $urandom_range(0, 1),
                longint'($urandom_range(1 << 21, 1 << 27)),
                longint'($urandom_range(1 << 22, 1 << 30)));
      end
      calm = (p == 2);
      for (int c = 0; c < 120; ) begin
        if ($urandom_range(0, 3) == 0) begin
          add_noise();
          c++;
        end else begin
          int len;
          len = $urandom_range(3, 12);
          add_series(len);
          c += len;
        end
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("itc_one_site_heat_model_tb: done, clean");
    end else begin
      $display("itc_one_site_heat_model_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("itc_one_site_heat_model_tb: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/itcoh_pkg.sv
hw/rtl/itcoh_front.sv
hw/rtl/itcoh_arith.sv
hw/rtl/itcoh_back.sv
hw/rtl/itc_one_site_heat_model.sv
hw/rtl/itcoh_checker.sv
tb/sv/itc_one_site_heat_model_tb.sv
